@@ src/kev_pkg.sv @@
package kev_pkg;

    localparam int KEY_LEVEL_W = 12;
    localparam int KEY_INDEX_W = 4;
    localparam int FLAG_W      = 7;
    localparam int TIMER_W     = 16;
    localparam int DIV_W       = 8;
    localparam int OP_W        = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int S_DATA_W    = 24;
    localparam int M_DATA_W    = 8;

    // item kinds carried on tuser
    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_CHECK = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_REPEAT       = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DOUBLE_WIN   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_DIV   = 2'd3;

    localparam logic [TIMER_W-1:0] LONG_PRESS_RESET = 16'd1000;
    localparam logic [TIMER_W-1:0] REPEAT_RESET     = 16'd100;
    localparam logic [TIMER_W-1:0] DOUBLE_WIN_RESET = 16'd0;
    localparam logic [DIV_W-1:0]   SAMPLE_DIV_RESET = 8'd20;

    // flag bit positions
    localparam int F_DOWN   = 0;
    localparam int F_UP     = 1;
    localparam int F_SINGLE = 2;
    localparam int F_DOUBLE = 3;
    localparam int F_LONG   = 4;
    localparam int F_REPEAT = 5;
    localparam int F_HOLD   = 6;

    localparam logic [FLAG_W-1:0] MASK_HOLD_ONLY = 7'b100_0000;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_PRESSED   = 3'd1,
        PH_DBL_WAIT  = 3'd2,
        PH_AFTER_DBL = 3'd3,
        PH_REPEAT    = 3'd4
    } kev_phase_t;

    typedef struct packed {
        logic [TIMER_W-1:0] long_ticks;
        logic [TIMER_W-1:0] repeat_ticks;
        logic [TIMER_W-1:0] dbl_ticks;
    } kev_cfg_t;

    typedef struct packed {
        logic              tick;
        logic              sample;
        logic              clear_all;
        logic [FLAG_W-1:0] clr_mask;
    } kev_ctrl_t;

endpackage

@@ src/kev_lane.sv @@
module kev_lane (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  kev_pkg::kev_ctrl_t            ctrl,
    input  kev_pkg::kev_cfg_t             cfg,
    input  logic                          level,
    input  logic                          clr_sel,
    output logic [kev_pkg::FLAG_W-1:0]    flags
);
    import kev_pkg::*;

    kev_phase_t         phase_reg, phase_next;
    logic [TIMER_W-1:0] timer_reg, timer_next, timer_dec;
    logic [FLAG_W-1:0]  flags_reg, flags_next;
    logic               level_reg, level_next;
    logic               do_sample;

    assign do_sample = ctrl.tick && ctrl.sample;
    assign timer_dec = (timer_reg != '0) ? timer_reg - 1'b1 : timer_reg;
    assign flags     = flags_reg;

    // phase transitions
    always_comb begin
        phase_next = phase_reg;
        if (ctrl.clear_all) begin
            phase_next = PH_IDLE;
        end else if (do_sample) begin
            unique case (phase_reg)
                PH_PRESSED: begin
                    if (!level) phase_next = PH_DBL_WAIT;
                    else if (timer_dec == '0) phase_next = PH_REPEAT;
                end
                PH_DBL_WAIT: begin
                    if (level) phase_next = PH_AFTER_DBL;
                    else if (timer_dec == '0) phase_next = PH_IDLE;
                end
                PH_AFTER_DBL: begin
                    if (!level) phase_next = PH_IDLE;
                end
                PH_REPEAT: begin
                    if (!level) phase_next = PH_IDLE;
                end
                default: begin
                    phase_next = level ? PH_PRESSED : PH_IDLE;
                end
            endcase
        end
    end

    // timer, level and flag updates
    always_comb begin
        timer_next = timer_reg;
        flags_next = flags_reg;
        level_next = level_reg;
        if (ctrl.clear_all) begin
            timer_next = '0;
            flags_next = '0;
            level_next = 1'b0;
        end else begin
            if (clr_sel) flags_next = flags_reg & ~ctrl.clr_mask;
            if (ctrl.tick) timer_next = timer_dec;
            if (do_sample) begin
                level_next         = level;
                flags_next[F_HOLD] = level;
                if (level && !level_reg) flags_next[F_DOWN] = 1'b1;
                if (!level && level_reg) flags_next[F_UP] = 1'b1;
                unique case (phase_reg)
                    PH_PRESSED: begin
                        if (!level) begin
                            timer_next = cfg.dbl_ticks;
                        end else if (timer_dec == '0) begin
                            timer_next         = cfg.repeat_ticks;
                            flags_next[F_LONG] = 1'b1;
                        end
                    end
                    PH_DBL_WAIT: begin
                        if (level) flags_next[F_DOUBLE] = 1'b1;
                        else if (timer_dec == '0) flags_next[F_SINGLE] = 1'b1;
                    end
                    PH_AFTER_DBL: begin
                    end
                    PH_REPEAT: begin
                        if (level && timer_dec == '0) begin
                            timer_next           = cfg.repeat_ticks;
                            flags_next[F_REPEAT] = 1'b1;
                        end
                    end
                    default: begin
                        if (level) timer_next = cfg.long_ticks;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            timer_reg <= '0;
            flags_reg <= '0;
            level_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            timer_reg <= timer_next;
            flags_reg <= flags_next;
            level_reg <= level_next;
        end
    end

endmodule

@@ src/kev_merge.sv @@
module kev_merge #(
    parameter int NUM_KEYS = 12
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        accept,
    input  logic [kev_pkg::OP_W-1:0]                    op,
    input  logic [kev_pkg::KEY_INDEX_W-1:0]             key_index,
    input  logic [kev_pkg::FLAG_W-1:0]                  event_mask,
    input  logic [NUM_KEYS-1:0][kev_pkg::FLAG_W-1:0]    lane_flags,
    input  logic                                        out_ready,
    output logic [NUM_KEYS-1:0]                         clr_vec,
    output logic                                        out_valid,
    output logic [kev_pkg::M_DATA_W-1:0]                out_data
);
    import kev_pkg::*;

    logic [FLAG_W-1:0]   sel_flags;
    logic [NUM_KEYS-1:0] sel_vec;
    logic                is_check, hit, do_clr;
    logic                valid_reg, valid_next;
    logic [M_DATA_W-1:0] data_reg, data_next;

    always_comb begin
        sel_flags = '0;
        for (int k = 0; k < NUM_KEYS; k++) begin
            sel_vec[k] = (32'(key_index) == k);
            if (sel_vec[k]) sel_flags = sel_flags | lane_flags[k];
        end
    end

    // an index past the last key matches no lane and reads as zero
    assign is_check = accept && (op == OP_CHECK);
    assign hit      = is_check && ((sel_flags & event_mask) != '0);
    assign do_clr   = hit && (event_mask != MASK_HOLD_ONLY);
    assign clr_vec  = do_clr ? sel_vec : '0;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (accept) begin
            valid_next = 1'b1;
            data_next  = is_check ? {sel_flags, hit} : '0;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) valid_reg <= 1'b0;
        else          valid_reg <= valid_next;
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ src/key_event_detector.sv @@
// a result is registered and appears in the cycle after its input transfer
// throughput: one item per cycle while the output is not stalled, all key lanes update in the same cycle
// an output register holds the result; a new item is taken while it is being drained
// reset (aresetn low, synchronous) clears all key state, the prescaler and the
// configuration registers to their defaults; clear items leave the registers alone
module key_event_detector #(
    parameter int NUM_KEYS = 12
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // key_levels [11:0], key_index [15:12], event_mask [22:16], zero [23]
    input  logic [kev_pkg::S_DATA_W-1:0]       s_tdata,
    // op [1:0]
    input  logic [kev_pkg::OP_W-1:0]           s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // hit [0], flags_seen [7:1]
    output logic [kev_pkg::M_DATA_W-1:0]       m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [kev_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [kev_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import kev_pkg::*;

    logic [TIMER_W-1:0] long_reg, repeat_reg, dbl_reg;
    logic [DIV_W-1:0]   div_reg, presc_reg, presc_next, presc_inc;
    kev_cfg_t           cfg;
    kev_ctrl_t          ctrl;
    logic               accept;
    logic [KEY_LEVEL_W-1:0] key_levels;
    logic [KEY_INDEX_W-1:0] key_index;
    logic [FLAG_W-1:0]      event_mask;
    logic [NUM_KEYS-1:0][FLAG_W-1:0] lane_flags;
    logic [NUM_KEYS-1:0]    clr_vec;

    assign key_levels = s_tdata[KEY_LEVEL_W-1:0];
    assign key_index  = s_tdata[KEY_LEVEL_W +: KEY_INDEX_W];
    assign event_mask = s_tdata[KEY_LEVEL_W+KEY_INDEX_W +: FLAG_W];

    assign s_tready  = !m_tvalid || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            long_reg   <= LONG_PRESS_RESET;
            repeat_reg <= REPEAT_RESET;
            dbl_reg    <= DOUBLE_WIN_RESET;
            div_reg    <= SAMPLE_DIV_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_LONG_PRESS: long_reg   <= cfg_data;
                REG_REPEAT:     repeat_reg <= cfg_data;
                REG_DOUBLE_WIN: dbl_reg    <= cfg_data;
                REG_SAMPLE_DIV: div_reg    <= cfg_data[DIV_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.long_ticks   = long_reg;
    assign cfg.repeat_ticks = repeat_reg;
    assign cfg.dbl_ticks    = dbl_reg;

    // sample when the wrapped prescaler count reaches or exceeds the divider
    assign presc_inc = presc_reg + 1'b1;

    always_comb begin
        ctrl.tick      = accept && (s_tuser == OP_TICK);
        ctrl.clear_all = accept && (s_tuser == OP_CLEAR);
        ctrl.sample    = (presc_inc >= div_reg);
        ctrl.clr_mask  = event_mask;
        presc_next     = presc_reg;
        if (ctrl.clear_all) presc_next = '0;
        else if (ctrl.tick) presc_next = ctrl.sample ? '0 : presc_inc;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) presc_reg <= '0;
        else          presc_reg <= presc_next;
    end

    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
        logic lvl;
        if (k < KEY_LEVEL_W) begin : g_in
            assign lvl = key_levels[k];
        end else begin : g_none
            assign lvl = 1'b0;
        end
        kev_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (ctrl),
            .cfg     (cfg),
            .level   (lvl),
            .clr_sel (clr_vec[k]),
            .flags   (lane_flags[k])
        );
    end

    kev_merge #(
        .NUM_KEYS (NUM_KEYS)
    ) u_merge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .op         (s_tuser),
        .key_index  (key_index),
        .event_mask (event_mask),
        .lane_flags (lane_flags),
        .out_ready  (m_tready),
        .clr_vec    (clr_vec),
        .out_valid  (m_tvalid),
        .out_data   (m_tdata)
    );

endmodule

@@ src/kev_checker.sv @@
module kev_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic [kev_pkg::OP_W-1:0]           s_tuser,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [kev_pkg::M_DATA_W-1:0]       m_tdata
);
    import kev_pkg::*;

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // input side opens whenever the output register is free or draining
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output register");

    // every transfer in gives a result next cycle; only checks carry data
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser != OP_CHECK |=> m_tvalid && m_tdata == '0)
        else $error("non-check item gave a nonzero or missing result");

    // a hit needs some flag to have been seen
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[M_DATA_W-1:1] != '0)
        else $error("hit reported with no flags");

endmodule

bind key_event_detector kev_checker u_kev_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import kev_pkg::*;

    localparam int NUM_KEYS = 12;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam logic [FLAG_W-1:0] MASK_NONE = 7'h00;
    localparam logic [FLAG_W-1:0] MASK_ALL = 7'h7f;

    typedef struct {
        logic              hit;
        logic [FLAG_W-1:0] flags;
    } key_report_t;

    // tracks per-key flags, levels, phases and timers; queues the report of every item
    class key_event_board;
        key_report_t pending_reports[$];
        logic [FLAG_W-1:0] key_flags[NUM_KEYS];
        logic key_level[NUM_KEYS];
        kev_phase_t key_phase[NUM_KEYS];
        logic [TIMER_W-1:0] key_timer[NUM_KEYS];
        logic [DIV_W-1:0] prescaler;
        logic [TIMER_W-1:0] long_ticks;
        logic [TIMER_W-1:0] repeat_ticks;
        logic [TIMER_W-1:0] dbl_ticks;
        logic [DIV_W-1:0] sample_div;
        int mismatches;

        function new();
            long_ticks = LONG_PRESS_RESET;
            repeat_ticks = REPEAT_RESET;
            dbl_ticks = DOUBLE_WIN_RESET;
            sample_div = SAMPLE_DIV_RESET;
            mismatches = 0;
            clear_keys();
        endfunction

        function void clear_keys();
            for (int k = 0; k < NUM_KEYS; k++) begin
                key_flags[k] = '0;
                key_level[k] = 1'b0;
                key_phase[k] = PH_IDLE;
                key_timer[k] = '0;
            end
            prescaler = '0;
        endfunction

        function void write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_LONG_PRESS: long_ticks = value;
                REG_REPEAT:     repeat_ticks = value;
                REG_DOUBLE_WIN: dbl_ticks = value;
                REG_SAMPLE_DIV: sample_div = value[DIV_W-1:0];
                default: ;
            endcase
        endfunction

        function void accept_item(logic [OP_W-1:0] op, logic [KEY_LEVEL_W-1:0] levels,
                                  logic [KEY_INDEX_W-1:0] idx, logic [FLAG_W-1:0] mask);
            key_report_t rep;
            logic [DIV_W-1:0] next_count;
            logic now;
            logic [FLAG_W-1:0] f;
            rep.hit = 1'b0;
            rep.flags = '0;
            case (op)
                OP_TICK: begin
                    for (int k = 0; k < NUM_KEYS; k++)
                        if (key_timer[k] != 0) key_timer[k]--;
                    next_count = prescaler + 8'd1;
                    if (next_count >= sample_div) begin
                        prescaler = '0;
                        for (int k = 0; k < NUM_KEYS; k++) begin
                            now = (k < KEY_LEVEL_W) ? levels[k] : 1'b0;
                            f = key_flags[k];
                            f[F_HOLD] = now;
                            if (now && !key_level[k]) f[F_DOWN] = 1'b1;
                            if (!now && key_level[k]) f[F_UP] = 1'b1;
                            key_level[k] = now;
                            case (key_phase[k])
                                PH_PRESSED: begin
                                    if (!now) begin
                                        key_timer[k] = dbl_ticks;
                                        key_phase[k] = PH_DBL_WAIT;
                                    end else if (key_timer[k] == 0) begin
                                        key_timer[k] = repeat_ticks;
                                        f[F_LONG] = 1'b1;
                                        key_phase[k] = PH_REPEAT;
                                    end
                                end
                                PH_DBL_WAIT: begin
                                    if (now) begin
                                        f[F_DOUBLE] = 1'b1;
                                        key_phase[k] = PH_AFTER_DBL;
                                    end else if (key_timer[k] == 0) begin
                                        f[F_SINGLE] = 1'b1;
                                        key_phase[k] = PH_IDLE;
                                    end
                                end
                                PH_AFTER_DBL: begin
                                    if (!now) key_phase[k] = PH_IDLE;
                                end
                                PH_REPEAT: begin
                                    if (!now) begin
                                        key_phase[k] = PH_IDLE;
                                    end else if (key_timer[k] == 0) begin
                                        key_timer[k] = repeat_ticks;
                                        f[F_REPEAT] = 1'b1;
                                    end
                                end
                                default: begin
                                    key_phase[k] = PH_IDLE;
                                    if (now) begin
                                        key_timer[k] = long_ticks;
                                        key_phase[k] = PH_PRESSED;
                                    end
                                end
                            endcase
                            key_flags[k] = f;
                        end
                    end else begin
                        prescaler = next_count;
                    end
                end
                OP_CHECK: begin
                    if (idx < NUM_KEYS) begin
                        rep.flags = key_flags[idx];
                        if ((key_flags[idx] & mask) != 0) begin
                            rep.hit = 1'b1;
                            // a hold-only query leaves the flags in place
                            if (mask != MASK_HOLD_ONLY) key_flags[idx] &= ~mask;
                        end
                    end
                end
                OP_CLEAR: clear_keys();
                default: ;
            endcase
            pending_reports.push_back(rep);
        endfunction

        function void flag_mismatch(string what);
            mismatches++;
            if (mismatches <= 10) $display("mismatch: %s", what);
        endfunction

        function void match_result(logic hit, logic [FLAG_W-1:0] flags);
            key_report_t rep;
            if (pending_reports.size() == 0) begin
                flag_mismatch($sformatf("result hit=%0b flags=%02h with nothing pending",
                                        hit, flags));
            end else begin
                rep = pending_reports.pop_front();
                if (rep.hit !== hit || rep.flags !== flags)
                    flag_mismatch($sformatf("expected hit=%0b flags=%02h, got hit=%0b flags=%02h",
                                            rep.hit, rep.flags, hit, flags));
            end
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_DATA_W-1:0]    s_tdata;
    logic [OP_W-1:0]        s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_DATA_W-1:0]    m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    key_event_board board = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_off_cycles = 0;
    int cycle_count = 0;

    key_event_detector #(
        .NUM_KEYS(NUM_KEYS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    // hit [0], flags_seen [7:1]
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.match_result(m_tdata[0], m_tdata[7:1]);
    end

    // receiver side; a nonzero hold-off keeps tready low until it has counted down to zero
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_cycles > 0) begin
                m_tready = 1'b0;
                hold_off_cycles--;
            end else begin
                m_tready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic send_item(input logic [OP_W-1:0] op, input logic [KEY_LEVEL_W-1:0] levels,
                             input logic [KEY_INDEX_W-1:0] idx, input logic [FLAG_W-1:0] mask);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser = op;
        s_tdata = {1'b0, mask, idx, levels};
        do @(posedge aclk); while (!s_tready);
        board.accept_item(op, levels, idx, mask);
        @(negedge aclk);
    endtask

    task automatic send_tick(input logic [KEY_LEVEL_W-1:0] levels);
        send_item(OP_TICK, levels, KEY_INDEX_W'($urandom), FLAG_W'($urandom));
    endtask

    task automatic send_check(input logic [KEY_INDEX_W-1:0] idx, input logic [FLAG_W-1:0] mask);
        send_item(OP_CHECK, KEY_LEVEL_W'($urandom), idx, mask);
    endtask

    task automatic wait_results_drained();
        s_tvalid = 1'b0;
        while (board.pending_reports.size() != 0) @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        do @(posedge aclk); while (!cfg_ready);
        board.write_register(idx, value);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_timing(input logic [TIMER_W-1:0] long_t, input logic [TIMER_W-1:0] rep_t,
                              input logic [TIMER_W-1:0] dbl_t, input logic [DIV_W-1:0] div);
        wait_results_drained();
        write_register(REG_LONG_PRESS, long_t);
        write_register(REG_REPEAT, rep_t);
        write_register(REG_DOUBLE_WIN, dbl_t);
        write_register(REG_SAMPLE_DIV, CFG_DATA_W'(div));
    endtask

    // mostly a few keys pressed and released in turn, checks in between, some noise
    task automatic run_key_traffic(input int n_items, input int stall_at, input bit pause_mid);
        logic [KEY_LEVEL_W-1:0] levels_held;
        logic [KEY_INDEX_W-1:0] kidx;
        logic [FLAG_W-1:0] emask;
        int roll;
        levels_held = '0;
        for (int i = 0; i < n_items; i++) begin
            if (i == stall_at) hold_off_cycles = 60;
            if (pause_mid && i == n_items / 2) wait_results_drained();
            roll = $urandom_range(99);
            if (roll < 58) begin
                if ($urandom_range(2) == 0)
                    levels_held ^= KEY_LEVEL_W'(1) <<
                        (($urandom_range(4) == 0) ? $urandom_range(11) : $urandom_range(2));
                send_tick(($urandom_range(19) == 0) ? KEY_LEVEL_W'($urandom) : levels_held);
            end else if (roll < 94) begin
                case ($urandom_range(9))
                    0: kidx = KEY_INDEX_W'($urandom_range(15));
                    1, 2: kidx = KEY_INDEX_W'($urandom_range(11));
                    default: kidx = KEY_INDEX_W'($urandom_range(2));
                endcase
                case ($urandom_range(9))
                    0: emask = MASK_HOLD_ONLY;
                    1: emask = MASK_NONE;
                    2: emask = MASK_ALL;
                    default: emask = FLAG_W'($urandom);
                endcase
                send_check(kidx, emask);
            end else if (roll < 97) begin
                send_item(OP_CLEAR, KEY_LEVEL_W'($urandom), KEY_INDEX_W'($urandom),
                          FLAG_W'($urandom));
            end else begin
                send_item(OP_UNUSED, KEY_LEVEL_W'($urandom), KEY_INDEX_W'($urandom),
                          FLAG_W'($urandom));
            end
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_TICK;
        cfg_valid = 1'b0;
        cfg_index = REG_LONG_PRESS;
        cfg_data = '0;
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // short timings so long, repeat, double and single all show up in a few ticks
        set_timing(16'd1, 16'd1, 16'd2, 8'd1);
        send_check(4'd0, MASK_ALL);
        send_tick(12'hfff);
        send_check(4'd11, MASK_HOLD_ONLY);
        send_check(4'd11, MASK_ALL);
        send_tick(12'hfff);
        send_tick(12'hfff);
        send_check(4'd5, 7'h30);
        send_tick(12'h000);
        send_tick(12'h001);
        send_tick(12'h000);
        send_tick(12'h001);
        send_tick(12'h000);
        send_tick(12'h800);
        send_tick(12'h000);
        send_tick(12'h000);
        send_tick(12'h000);
        send_check(4'd0, 7'h08);
        send_check(4'd11, 7'h04);
        send_check(4'd12, MASK_ALL);
        send_check(4'd15, MASK_ALL);
        send_check(4'd1, MASK_NONE);
        send_item(OP_UNUSED, 12'hfff, 4'd15, MASK_ALL);
        send_item(OP_CLEAR, 12'h000, 4'd0, MASK_NONE);
        send_check(4'd3, MASK_ALL);

        // divider lowered below the running prescaler
        set_timing(16'd1, 16'd1, 16'd2, 8'd20);
        repeat (4) send_tick(12'hfff);
        wait_results_drained();
        write_register(REG_SAMPLE_DIV, 16'd2);
        send_tick(12'hfff);
        send_check(4'd2, MASK_ALL);

        set_timing(16'd3, 16'd2, 16'd4, 8'd1);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        run_key_traffic(160, -1, 1'b1);

        // zero divider samples on every tick
        set_timing(16'd0, 16'd0, 16'd0, 8'd0);
        send_idle_pct = 53;
        recv_stall_pct = 0;
        run_key_traffic(160, 50, 1'b0);

        set_timing(16'd6, 16'd3, 16'd8, 8'd2);
        send_idle_pct = 0;
        recv_stall_pct = 53;
        run_key_traffic(160, 80, 1'b0);

        set_timing(16'hffff, 16'hffff, 16'hffff, 8'd255);
        send_idle_pct = 15;
        recv_stall_pct = 15;
        run_key_traffic(80, -1, 1'b0);

        set_timing(TIMER_W'($urandom_range(12)), TIMER_W'($urandom_range(6)),
                   TIMER_W'($urandom_range(10)), DIV_W'($urandom_range(1, 4)));
        send_idle_pct = 15;
        recv_stall_pct = 15;
        run_key_traffic(190, 30, 1'b1);

        wait_results_drained();
        repeat (5) @(negedge aclk);
        if (board.mismatches == 0 && board.pending_reports.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
